// ===== hw/rtl/sink_route_update_and_decision_defines.svh =====
// Assertion macros for the sink route keeper.
`ifndef SINK_ROUTE_UPDATE_AND_DECISION_DEFINES_SVH
`define SINK_ROUTE_UPDATE_AND_DECISION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRUD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRUD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srud_pkg.sv =====
// Shared types and constants for the sink route keeper.
package srud_pkg;

  localparam int unsigned SLOT_BASE  = 5000;
  localparam int unsigned SLOT_STEP  = 1000;
  localparam int unsigned SLOT_GRACE = 900;
  // 5000 + 1000 * 255 fits in 18 bits
  localparam int unsigned SLOT_T_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_INFO  = 2'd0,
    FUNC_ROUTE = 2'd1,
    FUNC_TIMER = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    DEC_LOCAL   = 3'd0,
    DEC_BCAST   = 3'd1,
    DEC_UNICAST = 3'd2,
    DEC_DROP    = 3'd3,
    DEC_NONE    = 3'd4
  } dec_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_ADDR = 3'd0,
    CFG_ROOT_ALIAS = 3'd1,
    CFG_BCAST_ADDR = 3'd2,
    CFG_MAX_HOPS   = 3'd3,
    CFG_VALID_TIME = 3'd4,
    CFG_SF_LEN     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_SLOT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/srud_mod.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module srud_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srud_pkg::div_req_t req_i,
  output srud_pkg::div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [31:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      dvd_d = req_i.dividend;
      dsr_d = req_i.divisor;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      rem_d  = ge ? diff[31:0] : trial[31:0];
      dvd_d  = {dvd_q[30:0], 1'b0};
      cnt_d  = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/sink_route_update_and_decision.sv =====
// Top level of the sink route keeper and packet router.
//
// Keeps one route toward the root and answers one request at a time. A request is
// taken when start is high and busy is low; busy then stays high until the result
// shows up on the output ports for exactly one cycle, flagged by done_o. The
// receiver cannot stall, so nothing is held back. Routing-info, timer-check,
// unused-code requests and route requests that do not end up as a unicast toward
// the root pass through ST_EVAL alone before done_o. A unicast toward the root
// needs the position inside the superframe, fixed_time modulo superframe_length,
// from the bit-serial remainder unit; it passes ST_EVAL, ST_DIV, ST_SLOT, ST_FIN
// (no ST_DIV when superframe_length is zero and no reduction is done). The next
// request may be accepted in the cycle in which done_o is high. Configuration
// writes land at the edge where cfg_we_i is high and must only come while idle.
module sink_route_update_and_decision (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request side
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func_i,
  input  logic [31:0]                         now_ticks_i,
  input  logic [31:0]                         fixed_time_i,
  input  logic [9:0]                          jitter_i,
  input  logic [15:0]                         src_address_i,
  input  logic [15:0]                         dst_address_i,
  input  logic                                is_local_origin_i,
  input  logic [15:0]                         info_seqnum_i,
  input  logic [7:0]                          info_hop_count_i,
  input  logic [15:0]                         info_root_address_i,
  input  logic [31:0]                         info_root_clock_i,
  input  logic [7:0]                          info_mote_number_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [srud_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srud_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // result side
  output logic                                done_o,
  output logic [2:0]                          decision_o,
  output logic [15:0]                         next_hop_o,
  output logic [15:0]                         dst_out_o,
  output logic [7:0]                          hop_limit_o,
  output logic [31:0]                         send_time_o,
  output logic                                send_request_o,
  output logic                                route_updated_o,
  output logic signed [31:0]                  root_clock_delta_o
);

  `include "sink_route_update_and_decision_defines.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] local_addr_q, root_alias_q, bcast_addr_q;
  logic [7:0]  max_hops_q;
  logic [31:0] valid_time_q, sf_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= 16'd0;
      root_alias_q <= 16'd65534;
      bcast_addr_q <= 16'd65535;
      max_hops_q   <= 8'd16;
      valid_time_q <= 32'd60000;
      sf_len_q     <= 32'd60000;
    end else if (cfg_we_i) begin
      unique case (srud_pkg::cfg_idx_e'(cfg_idx_i))
        srud_pkg::CFG_LOCAL_ADDR: local_addr_q <= cfg_data_i[15:0];
        srud_pkg::CFG_ROOT_ALIAS: root_alias_q <= cfg_data_i[15:0];
        srud_pkg::CFG_BCAST_ADDR: bcast_addr_q <= cfg_data_i[15:0];
        srud_pkg::CFG_MAX_HOPS:   max_hops_q   <= cfg_data_i[7:0];
        srud_pkg::CFG_VALID_TIME: valid_time_q <= cfg_data_i;
        srud_pkg::CFG_SF_LEN:     sf_len_q     <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Route state
  // ---------------------------------------------------------------------------
  logic [15:0] seen_seq_q, seen_seq_d;
  logic [7:0]  hops_root_q, hops_root_d;
  logic [31:0] upd_time_q, upd_time_d;
  logic [15:0] parent_q, parent_d;
  logic [15:0] root_addr_q, root_addr_d;
  logic [31:0] clk_delta_q, clk_delta_d;
  logic [7:0]  slot_idx_q, slot_idx_d;

  // ---------------------------------------------------------------------------
  // Captured request
  // ---------------------------------------------------------------------------
  logic [1:0]  func_q;
  logic [31:0] now_q, fixed_q, rclock_q;
  logic [9:0]  jitter_q;
  logic [15:0] src_q, dst_q, seq_q, raddr_q;
  logic        lo_q;
  logic [7:0]  hops_q, mote_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q   <= func_i;
      now_q    <= now_ticks_i;
      fixed_q  <= fixed_time_i;
      jitter_q <= jitter_i;
      src_q    <= src_address_i;
      dst_q    <= dst_address_i;
      lo_q     <= is_local_origin_i;
      seq_q    <= info_seqnum_i;
      hops_q   <= info_hop_count_i;
      raddr_q  <= info_root_address_i;
      rclock_q <= info_root_clock_i;
      mote_q   <= info_mote_number_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------------
  srud_pkg::state_e state_q, state_d;
  srud_pkg::div_req_t div_req;
  srud_pkg::div_rsp_t div_rsp;

  logic [srud_pkg::SLOT_T_W-1:0] slot_t_q, slot_t_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic        near_q, near_d;

  logic        done_q, done_d;
  srud_pkg::dec_e dec_q, dec_d;
  logic [15:0] next_hop_q, next_hop_d;
  logic [15:0] dst_out_q, dst_out_d;
  logic [7:0]  hop_lim_q, hop_lim_d;
  logic [31:0] send_time_q, send_time_d;
  logic        send_req_q, send_req_d;
  logic        updated_q, updated_d;
  logic [31:0] delta_out_q, delta_out_d;

  // validity: hop count below the maximum and not past update_time + valid_time
  logic [31:0] expiry_diff;
  logic        hop_ok, expired, valid;
  logic [15:0] seq_diff;
  logic        newer, take;
  logic        rewrite, hit_local, is_bc, is_root;
  logic [15:0] dst_eff;
  logic [31:0] slot_t_ext;
  logic        slot_lt;

  assign expiry_diff = upd_time_q + valid_time_q - now_q;
  assign hop_ok      = hops_root_q < max_hops_q;
  assign expired     = expiry_diff[31];
  assign valid       = hop_ok && !expired;

  // wrapping 16-bit sequence compare
  assign seq_diff = seen_seq_q - seq_q;
  assign newer    = seq_diff[15];
  assign take     = (!valid || newer || (seq_q == seen_seq_q && hops_q < hops_root_q))
                    && !(hops_q > max_hops_q);

  // root alias rewrite for locally generated packets
  assign rewrite   = lo_q && (dst_q == root_alias_q);
  assign dst_eff   = rewrite ? root_addr_q : dst_q;
  assign hit_local = dst_eff == local_addr_q;
  assign is_bc     = dst_eff == bcast_addr_q;
  assign is_root   = dst_eff == root_addr_q;

  assign slot_t_ext = {{(32-srud_pkg::SLOT_T_W){1'b0}}, slot_t_q};
  assign slot_lt    = slot_t_ext < pos_q;

  always_comb begin
    state_d     = state_q;
    seen_seq_d  = seen_seq_q;
    hops_root_d = hops_root_q;
    upd_time_d  = upd_time_q;
    parent_d    = parent_q;
    root_addr_d = root_addr_q;
    clk_delta_d = clk_delta_q;
    slot_idx_d  = slot_idx_q;
    slot_t_d    = slot_t_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    near_d      = near_q;
    done_d      = 1'b0;
    dec_d       = dec_q;
    next_hop_d  = next_hop_q;
    dst_out_d   = dst_out_q;
    hop_lim_d   = hop_lim_q;
    send_time_d = send_time_q;
    send_req_d  = send_req_q;
    updated_d   = updated_q;
    delta_out_d = delta_out_q;
    div_req.start    = 1'b0;
    div_req.dividend = fixed_q;
    div_req.divisor  = sf_len_q;

    unique case (state_q)
      srud_pkg::ST_IDLE: begin
        if (start) state_d = srud_pkg::ST_EVAL;
      end

      srud_pkg::ST_EVAL: begin
        dec_d       = srud_pkg::DEC_NONE;
        next_hop_d  = '0;
        dst_out_d   = '0;
        hop_lim_d   = '0;
        send_time_d = '0;
        send_req_d  = 1'b0;
        updated_d   = 1'b0;
        delta_out_d = clk_delta_q;
        done_d      = 1'b1;
        state_d     = srud_pkg::ST_IDLE;
        case (srud_pkg::func_e'(func_q))
          srud_pkg::FUNC_INFO: begin
            if (hop_ok && expired) hops_root_d = max_hops_q;
            if (take) begin
              root_addr_d = raddr_q;
              parent_d    = src_q;
              seen_seq_d  = seq_q;
              hops_root_d = hops_q;
              upd_time_d  = now_q;
              clk_delta_d = rclock_q - now_q;
              slot_idx_d  = mote_q;
              delta_out_d = rclock_q - now_q;
              updated_d   = 1'b1;
            end
          end
          srud_pkg::FUNC_ROUTE: begin
            dst_out_d = dst_eff;
            hop_lim_d = rewrite ? max_hops_q : 8'd0;
            if (hit_local) begin
              dec_d = srud_pkg::DEC_LOCAL;
            end else if (is_bc) begin
              dec_d = lo_q ? srud_pkg::DEC_BCAST : srud_pkg::DEC_LOCAL;
            end else if (is_root) begin
              // route requests check validity (with expiry side effect) only here
              if (hop_ok && expired) hops_root_d = max_hops_q;
              if (valid && lo_q) begin
                dec_d      = srud_pkg::DEC_UNICAST;
                next_hop_d = parent_q;
                slot_t_d   = srud_pkg::SLOT_T_W'(srud_pkg::SLOT_BASE)
                             + srud_pkg::SLOT_T_W'(slot_idx_q)
                             * srud_pkg::SLOT_T_W'(srud_pkg::SLOT_STEP);
                done_d     = 1'b0;
                if (sf_len_q == 32'd0) begin
                  pos_d   = fixed_q;
                  state_d = srud_pkg::ST_SLOT;
                end else begin
                  div_req.start = 1'b1;
                  state_d       = srud_pkg::ST_DIV;
                end
              end else begin
                dec_d = srud_pkg::DEC_DROP;
              end
            end else begin
              dec_d = lo_q ? srud_pkg::DEC_UNICAST : srud_pkg::DEC_DROP;
            end
          end
          srud_pkg::FUNC_TIMER: begin
            if (hop_ok && expired) hops_root_d = max_hops_q;
            send_req_d = !valid;
          end
          default: ;  // unused code: no state change, decision none
        endcase
      end

      srud_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          pos_d   = div_rsp.rem;
          state_d = srud_pkg::ST_SLOT;
        end
      end

      srud_pkg::ST_SLOT: begin
        // slot already passed: send now if within grace, else next superframe
        near_d  = slot_lt && (slot_t_ext + 32'(srud_pkg::SLOT_GRACE) > pos_q);
        acc_d   = slot_lt ? slot_t_ext + sf_len_q - pos_q : slot_t_ext - pos_q;
        state_d = srud_pkg::ST_FIN;
      end

      srud_pkg::ST_FIN: begin
        send_time_d = near_q ? 32'd0 : acc_q + {22'd0, jitter_q} + fixed_q;
        done_d      = 1'b1;
        state_d     = srud_pkg::ST_IDLE;
      end

      default: state_d = srud_pkg::ST_IDLE;
    endcase
  end

  srud_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srud_pkg::ST_IDLE;
      done_q      <= 1'b0;
      seen_seq_q  <= '0;
      hops_root_q <= 8'd16;
      upd_time_q  <= '0;
      parent_q    <= '0;
      root_addr_q <= '0;
      clk_delta_q <= '0;
      slot_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      seen_seq_q  <= seen_seq_d;
      hops_root_q <= hops_root_d;
      upd_time_q  <= upd_time_d;
      parent_q    <= parent_d;
      root_addr_q <= root_addr_d;
      clk_delta_q <= clk_delta_d;
      slot_idx_q  <= slot_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_t_q    <= slot_t_d;
    pos_q       <= pos_d;
    acc_q       <= acc_d;
    near_q      <= near_d;
    dec_q       <= dec_d;
    next_hop_q  <= next_hop_d;
    dst_out_q   <= dst_out_d;
    hop_lim_q   <= hop_lim_d;
    send_time_q <= send_time_d;
    send_req_q  <= send_req_d;
    updated_q   <= updated_d;
    delta_out_q <= delta_out_d;
  end

  assign busy               = state_q != srud_pkg::ST_IDLE;
  assign done_o             = done_q;
  assign decision_o         = dec_q;
  assign next_hop_o         = next_hop_q;
  assign dst_out_o          = dst_out_q;
  assign hop_limit_o        = hop_lim_q;
  assign send_time_o        = send_time_q;
  assign send_request_o     = send_req_q;
  assign route_updated_o    = updated_q;
  assign root_clock_delta_o = delta_out_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // a result is only shown once the sequencer is back to idle
  `SRUD_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while busy")
  // an accepted request always occupies the block on the next cycle
  `SRUD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not busy")
  // only a unicast carries a send time
  `SRUD_ASSERT_NOW(a_send_time, done_o && decision_o != srud_pkg::DEC_UNICAST,
                   send_time_o == 32'd0, "send time on non-unicast result")
  // the remainder unit only reports while its result is awaited
  `SRUD_ASSERT_NOW(a_div_state, div_rsp.done, state_q == srud_pkg::ST_DIV,
                   "remainder ready outside divide wait")

endmodule

// ===== dv/sink_route_checker.sv =====
`timescale 1ns / 1ps
// Route keeper checker: shadows config and route state, predicts each result, compares.
module sink_route_checker
  import srud_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         func_i,
  input  logic [31:0]        now_ticks_i,
  input  logic [31:0]        fixed_time_i,
  input  logic [9:0]         jitter_i,
  input  logic [15:0]        src_address_i,
  input  logic [15:0]        dst_address_i,
  input  logic               is_local_origin_i,
  input  logic [15:0]        info_seqnum_i,
  input  logic [7:0]         info_hop_count_i,
  input  logic [15:0]        info_root_address_i,
  input  logic [31:0]        info_root_clock_i,
  input  logic [7:0]         info_mote_number_i,
  input  logic               cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic               done_i,
  input  logic [2:0]         decision_i,
  input  logic [15:0]        next_hop_i,
  input  logic [15:0]        dst_out_i,
  input  logic [7:0]         hop_limit_i,
  input  logic [31:0]        send_time_i,
  input  logic               send_request_i,
  input  logic               route_updated_i,
  input  logic signed [31:0] root_clock_delta_i,
  output int unsigned        open_cnt_o,
  output int unsigned        mismatch_cnt_o
);

  typedef struct packed {
    dec_e               decision;
    logic [15:0]        next_hop;
    logic [15:0]        dst_out;
    logic [7:0]         hop_limit;
    logic [31:0]        send_time;
    logic               send_request;
    logic               route_updated;
    logic signed [31:0] clock_delta;
  } route_result_t;

  // shadow configuration
  logic [15:0] cfg_local_addr;
  logic [15:0] cfg_root_alias;
  logic [15:0] cfg_bcast_addr;
  logic [7:0]  cfg_max_hops;
  logic [31:0] cfg_valid_ticks;
  logic [31:0] cfg_sf_len;

  // shadow route
  logic [15:0] seen_seq;
  logic [7:0]  hops_to_root;
  logic [31:0] last_update;
  logic [15:0] parent_addr;
  logic [15:0] root_addr;
  logic [31:0] clock_offset;
  logic [7:0]  slot_idx;

  route_result_t results_due[$];
  int unsigned   results_seen;

  initial mismatch_cnt_o = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_cnt_o++;
  endtask

  // Valid while hops are below the limit and the lifetime has not run out;
  // finding it run out marks the route dead.
  function automatic bit route_live(input logic [31:0] now);
    logic [31:0] margin;
    margin = last_update + cfg_valid_ticks - now;
    if (hops_to_root >= cfg_max_hops) return 1'b0;
    if (margin[31]) begin
      hops_to_root = cfg_max_hops;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic route_result_t predict_route_result();
    route_result_t r;
    logic [15:0]   dst;
    logic [15:0]   seq_gap;
    logic [31:0]   slot_t;
    logic [31:0]   pos;
    bit            live;
    bit            take;
    r          = '0;
    r.decision = DEC_NONE;
    dst        = dst_address_i;
    case (func_e'(func_i))
      FUNC_INFO: begin
        seq_gap = seen_seq - info_seqnum_i;
        live    = route_live(now_ticks_i);
        take    = !live || seq_gap[15] ||
                  (info_seqnum_i == seen_seq && info_hop_count_i < hops_to_root);
        if (info_hop_count_i > cfg_max_hops) take = 1'b0;
        if (take) begin
          root_addr       = info_root_address_i;
          parent_addr     = src_address_i;
          seen_seq        = info_seqnum_i;
          hops_to_root    = info_hop_count_i;
          last_update     = now_ticks_i;
          clock_offset    = info_root_clock_i - now_ticks_i;
          slot_idx        = info_mote_number_i;
          r.route_updated = 1'b1;
        end
      end
      FUNC_ROUTE: begin
        if (is_local_origin_i && dst == cfg_root_alias) begin
          dst         = root_addr;
          r.hop_limit = cfg_max_hops;
        end
        r.dst_out = dst;
        if (dst == cfg_local_addr) begin
          r.decision = DEC_LOCAL;
        end else if (dst == cfg_bcast_addr) begin
          r.decision = is_local_origin_i ? DEC_BCAST : DEC_LOCAL;
        end else if (dst == root_addr) begin
          live = route_live(now_ticks_i);
          if (live && is_local_origin_i) begin
            r.decision = DEC_UNICAST;
            r.next_hop = parent_addr;
            slot_t     = SLOT_BASE + SLOT_STEP * slot_idx;
            pos        = (cfg_sf_len != 0) ? fixed_time_i % cfg_sf_len : fixed_time_i;
            // just missed our slot: send now
            if (slot_t < pos && slot_t + SLOT_GRACE > pos) begin
              r.send_time = '0;
            end else begin
              if (slot_t < pos) slot_t = slot_t + cfg_sf_len;
              r.send_time = slot_t - pos + jitter_i + fixed_time_i;
            end
          end else begin
            r.decision = DEC_DROP;
          end
        end else begin
          r.decision = is_local_origin_i ? DEC_UNICAST : DEC_DROP;
        end
      end
      FUNC_TIMER: r.send_request = !route_live(now_ticks_i);
      default: ;
    endcase
    r.clock_delta = clock_offset;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t want;
    if (!rst_ni) begin
      cfg_local_addr  = 16'h0000;
      cfg_root_alias  = 16'hFFFE;
      cfg_bcast_addr  = 16'hFFFF;
      cfg_max_hops    = 8'd16;
      cfg_valid_ticks = 32'd60000;
      cfg_sf_len      = 32'd60000;
      seen_seq        = '0;
      hops_to_root    = 8'd16;
      last_update     = '0;
      parent_addr     = '0;
      root_addr       = '0;
      clock_offset    = '0;
      slot_idx        = '0;
      results_due.delete();
      results_seen    = 0;
      open_cnt_o     <= 0;
    end else begin
      // a done may share its edge with the next accept; it belongs to the older request
      if (done_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = results_due.pop_front();
          if (decision_i !== want.decision)
            report_mismatch($sformatf("decision got %0d want %0d", decision_i, want.decision));
          if (next_hop_i !== want.next_hop)
            report_mismatch($sformatf("next_hop got %h want %h", next_hop_i, want.next_hop));
          if (dst_out_i !== want.dst_out)
            report_mismatch($sformatf("dst_out got %h want %h", dst_out_i, want.dst_out));
          if (hop_limit_i !== want.hop_limit)
            report_mismatch($sformatf("hop_limit got %0d want %0d", hop_limit_i,
                                      want.hop_limit));
          if (send_time_i !== want.send_time)
            report_mismatch($sformatf("send_time got %h want %h", send_time_i,
                                      want.send_time));
          if (send_request_i !== want.send_request)
            report_mismatch($sformatf("send_request got %b want %b", send_request_i,
                                      want.send_request));
          if (route_updated_i !== want.route_updated)
            report_mismatch($sformatf("route_updated got %b want %b", route_updated_i,
                                      want.route_updated));
          if (root_clock_delta_i !== want.clock_delta)
            report_mismatch($sformatf("root_clock_delta got %h want %h", root_clock_delta_i,
                                      want.clock_delta));
        end
        results_seen++;
      end
      if (start_i && !busy_i) results_due.push_back(predict_route_result());
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_LOCAL_ADDR: cfg_local_addr  = cfg_data_i[15:0];
          CFG_ROOT_ALIAS: cfg_root_alias  = cfg_data_i[15:0];
          CFG_BCAST_ADDR: cfg_bcast_addr  = cfg_data_i[15:0];
          CFG_MAX_HOPS:   cfg_max_hops    = cfg_data_i[7:0];
          CFG_VALID_TIME: cfg_valid_ticks = cfg_data_i;
          CFG_SF_LEN:     cfg_sf_len      = cfg_data_i;
          default: ;
        endcase
      end
      open_cnt_o <= results_due.size();
    end
  end

endmodule

// ===== dv/tb_sink_route_update_and_decision.sv =====
`timescale 1ns / 1ps
// Testbench top for the sink route keeper: clock, reset, stimulus, watchdog and verdict.
module tb_sink_route_update_and_decision;
  import srud_pkg::*;

  // extra wait when draining; the slowest request is a unicast to root
  localparam int unsigned DRAIN_CYCLES    = 40;
  // cycles with no request, result or register write before giving up
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 230;
  localparam int unsigned MAX_GAP         = 45;

  typedef struct {
    func_e       func;
    logic [31:0] now;
    logic [31:0] fixed;
    logic [9:0]  jitter;
    logic [15:0] src;
    logic [15:0] dst;
    logic        local_origin;
    logic [15:0] seq;
    logic [7:0]  hops;
    logic [15:0] root;
    logic [31:0] root_clock;
    logic [7:0]  mote;
  } route_req_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic [1:0]  func_i            = '0;
  logic [31:0] now_ticks_i       = '0;
  logic [31:0] fixed_time_i      = '0;
  logic [9:0]  jitter_i          = '0;
  logic [15:0] src_address_i     = '0;
  logic [15:0] dst_address_i     = '0;
  logic        is_local_origin_i = 1'b0;
  logic [15:0] info_seqnum_i     = '0;
  logic [7:0]  info_hop_count_i  = '0;
  logic [15:0] info_root_address_i = '0;
  logic [31:0] info_root_clock_i = '0;
  logic [7:0]  info_mote_number_i = '0;
  logic        cfg_we_i          = 1'b0;
  cfg_idx_e    cfg_idx_i         = CFG_LOCAL_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic               done_o;
  logic [2:0]         decision_o;
  logic [15:0]        next_hop_o;
  logic [15:0]        dst_out_o;
  logic [7:0]         hop_limit_o;
  logic [31:0]        send_time_o;
  logic               send_request_o;
  logic               route_updated_o;
  logic signed [31:0] root_clock_delta_o;

  int unsigned open_cnt;
  int unsigned mismatch_cnt;

  // What the generator last wrote, used only to aim the random stimulus.
  logic [15:0] gen_local;
  logic [15:0] gen_alias;
  logic [15:0] gen_bcast;
  logic [7:0]  gen_hops;
  logic [31:0] gen_sf;
  int unsigned tick_step;
  logic [31:0] tick_now;
  logic [15:0] seq_base;
  logic [15:0] root_pool[4];
  logic [7:0]  mote_pool[2];

  always #5 clk_i = ~clk_i;

  sink_route_update_and_decision i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .func_i             (func_i),
    .now_ticks_i        (now_ticks_i),
    .fixed_time_i       (fixed_time_i),
    .jitter_i           (jitter_i),
    .src_address_i      (src_address_i),
    .dst_address_i      (dst_address_i),
    .is_local_origin_i  (is_local_origin_i),
    .info_seqnum_i      (info_seqnum_i),
    .info_hop_count_i   (info_hop_count_i),
    .info_root_address_i(info_root_address_i),
    .info_root_clock_i  (info_root_clock_i),
    .info_mote_number_i (info_mote_number_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .decision_o         (decision_o),
    .next_hop_o         (next_hop_o),
    .dst_out_o          (dst_out_o),
    .hop_limit_o        (hop_limit_o),
    .send_time_o        (send_time_o),
    .send_request_o     (send_request_o),
    .route_updated_o    (route_updated_o),
    .root_clock_delta_o (root_clock_delta_o)
  );

  sink_route_checker i_route_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .func_i             (func_i),
    .now_ticks_i        (now_ticks_i),
    .fixed_time_i       (fixed_time_i),
    .jitter_i           (jitter_i),
    .src_address_i      (src_address_i),
    .dst_address_i      (dst_address_i),
    .is_local_origin_i  (is_local_origin_i),
    .info_seqnum_i      (info_seqnum_i),
    .info_hop_count_i   (info_hop_count_i),
    .info_root_address_i(info_root_address_i),
    .info_root_clock_i  (info_root_clock_i),
    .info_mote_number_i (info_mote_number_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .done_i             (done_o),
    .decision_i         (decision_o),
    .next_hop_i         (next_hop_o),
    .dst_out_i          (dst_out_o),
    .hop_limit_i        (hop_limit_o),
    .send_time_i        (send_time_o),
    .send_request_i     (send_request_o),
    .route_updated_i    (route_updated_o),
    .root_clock_delta_i (root_clock_delta_o),
    .open_cnt_o         (open_cnt),
    .mismatch_cnt_o     (mismatch_cnt)
  );

  // Present one request and hold it until the edge that takes it (start high, busy low).
  // Returns at that edge; start is left high so a back-to-back request keeps it up.
  task automatic drive_request(input route_req_t r);
    start               <= 1'b1;
    func_i              <= r.func;
    now_ticks_i         <= r.now;
    fixed_time_i        <= r.fixed;
    jitter_i            <= r.jitter;
    src_address_i       <= r.src;
    dst_address_i       <= r.dst;
    is_local_origin_i   <= r.local_origin;
    info_seqnum_i       <= r.seq;
    info_hop_count_i    <= r.hops;
    info_root_address_i <= r.root;
    info_root_clock_i   <= r.root_clock;
    info_mote_number_i  <= r.mote;
    do @(posedge clk_i); while (busy);
  endtask

  // Stop requesting, let every pending result come back, then give the block its
  // full latency on top. The first edge makes the checker's count include the last
  // accepted request.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (open_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_we_i high; the caller lowers it after the last write.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [15:0] local_addr, input logic [15:0] alias_addr,
                              input logic [15:0] bcast_addr, input logic [7:0] max_hops,
                              input logic [31:0] valid_ticks, input logic [31:0] sf_len);
    drain();
    write_reg(CFG_LOCAL_ADDR, {16'h0, local_addr});
    write_reg(CFG_ROOT_ALIAS, {16'h0, alias_addr});
    write_reg(CFG_BCAST_ADDR, {16'h0, bcast_addr});
    write_reg(CFG_MAX_HOPS,   {24'h0, max_hops});
    write_reg(CFG_VALID_TIME, valid_ticks);
    write_reg(CFG_SF_LEN,     sf_len);
    cfg_we_i  <= 1'b0;
    gen_local  = local_addr;
    gen_alias  = alias_addr;
    gen_bcast  = bcast_addr;
    gen_hops   = max_hops;
    gen_sf     = sf_len;
    // small clock steps relative to the lifetime so routes live for a while
    tick_step  = (valid_ticks >> 2) + 1;
  endtask

  function automatic route_req_t mk_req(input func_e f, input logic [31:0] now, fixed,
                                        input logic [9:0] jit, input logic [15:0] src, dst,
                                        input logic lo, input logic [15:0] seq,
                                        input logic [7:0] hops, input logic [15:0] root,
                                        input logic [31:0] rclk, input logic [7:0] mote);
    route_req_t r;
    r.func = f;   r.now = now;   r.fixed = fixed; r.jitter = jit;
    r.src = src;  r.dst = dst;   r.local_origin = lo;
    r.seq = seq;  r.hops = hops; r.root = root;   r.root_clock = rclk; r.mote = mote;
    return r;
  endfunction

  // Mostly coherent traffic: clock creeping forward, sequence numbers around the
  // current one, roots and slots from small pools so updates and unicasts to the
  // root actually happen. The rest is noise over the full field ranges.
  function automatic route_req_t random_request();
    route_req_t  r;
    int unsigned pick;
    int unsigned span;
    logic [7:0]  aim;
    pick   = $urandom_range(99);
    r.func = (pick < 35) ? FUNC_INFO : (pick < 80) ? FUNC_ROUTE :
             (pick < 95) ? FUNC_TIMER : FUNC_NONE;
    if ($urandom_range(19) == 0) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(0, tick_step);
    r.now = tick_now;

    // aim part of the packets at the edges of our slot
    aim = mote_pool[$urandom_range(1)];
    if ($urandom_range(1) == 0) begin
      r.fixed = $urandom();
    end else begin
      span    = (gen_sf == 0) ? 0 : 32'hFFFF_FFFF / gen_sf;
      r.fixed = gen_sf * $urandom_range(0, span) + SLOT_BASE + SLOT_STEP * aim +
                $urandom_range(0, 2000) - 1000;
    end
    r.jitter = 10'($urandom_range(1023));
    r.src    = 16'($urandom_range(16'hFFFF));

    pick = $urandom_range(99);
    if (pick < 20)      r.dst = gen_local;
    else if (pick < 35) r.dst = gen_alias;
    else if (pick < 50) r.dst = gen_bcast;
    else if (pick < 75) r.dst = root_pool[$urandom_range(3)];
    else                r.dst = 16'($urandom_range(16'hFFFF));
    r.local_origin = ($urandom_range(9) < 7);

    if ($urandom_range(9) == 0) r.seq = 16'($urandom_range(16'hFFFF));
    else r.seq = 16'(seq_base + $urandom_range(0, 3) - 1);
    if (r.func == FUNC_INFO) seq_base = 16'(seq_base + $urandom_range(0, 2));
    r.hops = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                      : 8'($urandom_range(0, gen_hops + 1));
    r.root = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF))
                                      : root_pool[$urandom_range(3)];
    r.root_clock = $urandom();
    r.mote = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : mote_pool[$urandom_range(1)];
    return r;
  endfunction

  // Watchdog: ends the run if nothing moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned idle_pct;
    tick_now = '0;
    seq_base = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_config(16'h0100, 16'hFFFE, 16'hFFFF, 8'd16, 32'd60000, 32'd60000);

    // ---- directed part, back to back ----
    // no route yet: timer asks for one
    drive_request(mk_req(FUNC_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // unused code with every field at its top value
    drive_request(mk_req(FUNC_NONE, '1, '1, '1, '1, '1, 1, '1, '1, '1, '1, '1));
    // first info on an invalid route is taken
    drive_request(mk_req(FUNC_INFO, 100, 0, 0, 16'h0002, 0, 0, 5, 3, 16'h0001,
                         32'h1000_0000, 2));
    // same sequence, fewer hops: taken; more hops: refused
    drive_request(mk_req(FUNC_INFO, 110, 0, 0, 16'h0003, 0, 0, 5, 2, 16'h0001,
                         32'h2000_0000, 2));
    drive_request(mk_req(FUNC_INFO, 115, 0, 0, 16'h0009, 0, 0, 5, 4, 16'h0001, 0, 2));
    // older sequence refused
    drive_request(mk_req(FUNC_INFO, 116, 0, 0, 16'h0009, 0, 0, 4, 1, 16'h0001, 0, 2));
    // newer across the half-range wrap, but advertised hops above the maximum
    drive_request(mk_req(FUNC_INFO, 117, 0, 0, 16'h0009, 0, 0, 16'h8005, 17, 16'h0001, 0, 2));
    // hops equal to the maximum is allowed and leaves the route dead
    drive_request(mk_req(FUNC_INFO, 120, 0, 0, 16'h0004, 0, 0, 6, 16, 16'h0001, 0, 2));
    drive_request(mk_req(FUNC_TIMER, 130, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // dead route gets replaced, slot 0
    drive_request(mk_req(FUNC_INFO, 200, 0, 0, 16'h0004, 0, 0, 6, 1, 16'h0001,
                         32'hFFFF_FF00, 0));
    // unicast to root through the alias: before the slot, inside the grace window,
    // past it, and at the top of time with jitter at its top value
    drive_request(mk_req(FUNC_ROUTE, 300, 1000, 0, 0, 16'hFFFE, 1, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 5500, 7, 0, 16'hFFFE, 1, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 6000, 999, 0, 16'hFFFE, 1, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 32'hFFFF_FFFF, 1023, 0, 16'hFFFE, 1, 0, 0, 0, 0, 0));
    // to root but forwarded: drop
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'h0001, 0, 0, 0, 0, 0, 0));
    // local, broadcast both ways, other destination from a local sender
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'h0100, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'h5A5A, 1, 0, 0, 0, 0, 0));
    // alias from a forwarded packet is not rewritten
    drive_request(mk_req(FUNC_ROUTE, 300, 0, 0, 0, 16'hFFFE, 0, 0, 0, 0, 0, 0));
    // lifetime boundary: last live tick, then first dead one
    drive_request(mk_req(FUNC_TIMER, 60200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_TIMER, 60201, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(FUNC_ROUTE, 60300, 1000, 0, 0, 16'hFFFE, 1, 0, 0, 0, 0, 0));
    // info extremes
    drive_request(mk_req(FUNC_INFO, '1, '1, '1, '1, '1, 1, '1, '1, '1, '1, '1));
    drive_request(mk_req(FUNC_INFO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // ---- random part, one configuration per phase ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;  // keep the directed setup
        // top values, and local = alias = broadcast
        1: apply_config(16'h0000, 16'h0000, 16'h0000, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // local equals broadcast, smallest limits
        2: apply_config(16'hFFFF, 16'h1234, 16'hFFFF, 8'd1, 32'd1, 32'd6000);
        // zero hop limit and zero superframe length
        3: apply_config(16'h0042, 16'hFFFE, 16'hFFFF, 8'd0, 32'd30000, 32'd0);
        7: apply_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                        16'($urandom_range(16'hFFFF)), 8'($urandom_range(1, 255)),
                        $urandom_range(1, 32'hFFFF_FFFF), $urandom_range(6000, 32'hFFFF_FFFF));
        default: apply_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(16'hFFFF)), 8'($urandom_range(2, 32)),
                              $urandom_range(1, 500000), $urandom_range(6000, 300000));
      endcase
      for (int k = 0; k < 4; k++) root_pool[k] = 16'($urandom_range(16'hFFFF));
      mote_pool[0] = 8'($urandom_range(0, 10));
      mote_pool[1] = 8'($urandom_range(0, 255));
      // no idling, sender idle 45 of 100, none, sender idle 32 of 100
      idle_pct = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 32 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        drive_request(random_request());
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
        end
      end
    end

    drain();
    if (mismatch_cnt == 0 && open_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
